### design/dbhold_pkg.sv
package dbhold_pkg;

  localparam int MAX_EVENTS = 4;
  localparam int DELAY_BITS = 16;
  localparam int US_PER_MS  = 1000;
  // A 16-bit millisecond count times 1000 fits in 26 bits.
  localparam int DLY_US_W   = 26;
  localparam int CNT_W      = 3;
  localparam int TIME_W     = 64;
  localparam int ADDR_W     = 6;
  localparam int DATA_W     = 64;

  localparam logic [2:0] REG_FLAG_MODE   = 3'd0;
  localparam logic [2:0] REG_DEBOUNCE_US = 3'd1;
  localparam logic [2:0] REG_EVENT_COUNT = 3'd2;
  localparam logic [2:0] REG_EVENT_LVLS  = 3'd3;
  localparam logic [2:0] REG_EVENT_DLYS  = 3'd4;

  localparam logic FLAG_MODE_RAW    = 1'b0;
  localparam logic FLAG_MODE_STABLE = 1'b1;

  typedef logic [DLY_US_W-1:0] dly_us_t;

  typedef struct packed {
    logic              pin_level;
    logic [TIME_W-1:0] time_us;
    logic              clear_high;
    logic              clear_low;
  } in_item_t;

  typedef struct packed {
    logic                  stable_level;
    logic                  high_seen;
    logic                  low_seen;
    logic [MAX_EVENTS-1:0] fired_mask;
  } out_item_t;

  typedef struct packed {
    logic                           flag_mode;
    logic [31:0]                    debounce_us;
    logic [CNT_W-1:0]               slots;
    logic [MAX_EVENTS-1:0]          levels;
    dly_us_t [MAX_EVENTS-1:0]       dly_us;
  } cfg_t;

  function automatic dly_us_t ms_to_us(input logic [DELAY_BITS-1:0] ms);
    return DLY_US_W'(ms) * DLY_US_W'(US_PER_MS);
  endfunction

endpackage

### design/dbhold_cfg.sv
module dbhold_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [dbhold_pkg::ADDR_W-1:0]      paddr,
  input  logic [dbhold_pkg::DATA_W-1:0]      pwdata,
  output logic [dbhold_pkg::DATA_W-1:0]      prdata,
  output logic                               pready,
  output dbhold_pkg::cfg_t                   cfg
);

  logic                                     flag_mode_r;
  logic [31:0]                              debounce_r;
  logic [dbhold_pkg::CNT_W-1:0]             count_r;
  logic [dbhold_pkg::MAX_EVENTS-1:0]        levels_r;
  logic [dbhold_pkg::DATA_W-1:0]            delays_r;
  dbhold_pkg::dly_us_t [dbhold_pkg::MAX_EVENTS-1:0] dly_us_r;
  logic                                     wr;
  logic [2:0]                               idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[5:3];

  // The hold times are kept in microseconds as well, so that the sample
  // path only has to compare.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_mode_r <= dbhold_pkg::FLAG_MODE_STABLE;
      debounce_r  <= '0;
      count_r     <= '0;
      levels_r    <= '0;
      delays_r    <= '0;
      dly_us_r    <= '0;
    end else if (wr) begin
      case (idx)
        dbhold_pkg::REG_FLAG_MODE:   flag_mode_r <= pwdata[0];
        dbhold_pkg::REG_DEBOUNCE_US: debounce_r  <= pwdata[31:0];
        dbhold_pkg::REG_EVENT_COUNT: count_r     <= pwdata[dbhold_pkg::CNT_W-1:0];
        dbhold_pkg::REG_EVENT_LVLS:  levels_r    <= pwdata[dbhold_pkg::MAX_EVENTS-1:0];
        dbhold_pkg::REG_EVENT_DLYS: begin
          delays_r <= pwdata;
          for (int i = 0; i < dbhold_pkg::MAX_EVENTS; i++) begin
            dly_us_r[i] <= dbhold_pkg::ms_to_us(
                pwdata[i*dbhold_pkg::DELAY_BITS +: dbhold_pkg::DELAY_BITS]);
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dbhold_pkg::REG_FLAG_MODE:   prdata = dbhold_pkg::DATA_W'(flag_mode_r);
      dbhold_pkg::REG_DEBOUNCE_US: prdata = dbhold_pkg::DATA_W'(debounce_r);
      dbhold_pkg::REG_EVENT_COUNT: prdata = dbhold_pkg::DATA_W'(count_r);
      dbhold_pkg::REG_EVENT_LVLS:  prdata = dbhold_pkg::DATA_W'(levels_r);
      dbhold_pkg::REG_EVENT_DLYS:  prdata = delays_r;
      default:                     prdata = '0;
    endcase
  end

  always_comb begin
    cfg.flag_mode   = flag_mode_r;
    cfg.debounce_us = debounce_r;
    cfg.levels      = levels_r;
    cfg.dly_us      = dly_us_r;
    if (count_r > dbhold_pkg::CNT_W'(dbhold_pkg::MAX_EVENTS)) begin
      cfg.slots = dbhold_pkg::CNT_W'(dbhold_pkg::MAX_EVENTS);
    end else begin
      cfg.slots = count_r;
    end
  end

endmodule

### design/debounced_input_hold_event_trigger_top.sv
// An accepted request's result is registered once the result register is free or drained.
// Throughput: one request per cycle while out_stall is low; the input register and the
// result register decouple the two channels, and the whole per-sample update is one pass of logic.
// Reset (rst_n, synchronous, active low) empties both registers, clears the
// debouncer state and flags, and returns the configuration registers to defaults.
module debounced_input_hold_event_trigger_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  dbhold_pkg::in_item_t           in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output dbhold_pkg::out_item_t          out_item,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dbhold_pkg::ADDR_W-1:0]  paddr,
  input  logic [dbhold_pkg::DATA_W-1:0]  pwdata,
  output logic [dbhold_pkg::DATA_W-1:0]  prdata,
  output logic                           pready
);

  localparam int TW = dbhold_pkg::TIME_W;
  localparam int NE = dbhold_pkg::MAX_EVENTS;
  localparam int DW = dbhold_pkg::DLY_US_W;

  dbhold_pkg::cfg_t      cfg;
  logic                  in_vld_r;
  dbhold_pkg::in_item_t  in_item_r;
  logic                  out_vld_r;
  dbhold_pkg::out_item_t out_item_r;

  logic                           started_r;
  logic                           stable_r;
  logic [TW-1:0]                  hold_r;
  logic [TW-1:0]                  accept_r;
  logic [NE-1:0]                  sent_r;
  logic [dbhold_pkg::CNT_W-1:0]   marks_len_r;
  logic                           high_r;
  logic                           low_r;

  logic                           move;
  logic                           level;
  logic [TW-1:0]                  now;
  logic [TW-1:0]                  hold_eff;
  logic                           stable_eff;
  logic [TW:0]                    hold_diff;
  logic                           reload;
  logic [TW-1:0]                  acc_diff;
  logic                           take;
  logic [TW-1:0]                  held;
  logic                           high_nxt;
  logic                           low_nxt;
  logic [NE-1:0]                  sent_base;
  logic [NE-1:0]                  fire;
  logic [dbhold_pkg::CNT_W-1:0]   marks_len_nxt;
  logic                           armed;
  logic                           stable_nxt;
  logic [TW-1:0]                  hold_nxt;
  logic [TW-1:0]                  accept_nxt;

  dbhold_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign move      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !move;
  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  assign level = in_item_r.pin_level;
  assign now   = in_item_r.time_us;

  // The first sample seeds the stable level and the hold start.
  assign hold_eff   = started_r ? hold_r : now;
  assign stable_eff = started_r ? stable_r : level;

  // Both differences are formed in parallel. A backwards timestamp reloads
  // both stored times, which makes the held time zero and blocks a level change for this sample.
  assign hold_diff = {1'b0, now} - {1'b0, hold_eff};
  assign reload    = hold_diff[TW];
  assign acc_diff  = now - accept_r;
  assign take      = (level != stable_eff) && !reload &&
                     (acc_diff > TW'(cfg.debounce_us));
  assign held      = (reload || take) ? '0 : hold_diff[TW-1:0];

  always_comb begin
    high_nxt = high_r && !in_item_r.clear_high;
    low_nxt  = low_r && !in_item_r.clear_low;
    if ((cfg.flag_mode == dbhold_pkg::FLAG_MODE_RAW) ||
        (cfg.flag_mode == dbhold_pkg::FLAG_MODE_STABLE && take)) begin
      if (level) begin
        high_nxt = 1'b1;
      end else begin
        low_nxt = 1'b1;
      end
    end
  end

  assign sent_base     = take ? '0 : sent_r;
  assign marks_len_nxt = take ? cfg.slots : marks_len_r;
  assign armed         = (marks_len_nxt == cfg.slots);

  always_comb begin
    for (int i = 0; i < NE; i++) begin
      fire[i] = armed && (dbhold_pkg::CNT_W'(i) < cfg.slots) &&
                (cfg.levels[i] == level) && !sent_base[i] &&
                ((held[TW-1:DW] != '0) || (held[DW-1:0] >= cfg.dly_us[i]));
    end
  end

  assign stable_nxt = take ? level : stable_eff;
  assign hold_nxt   = (take || reload) ? now : hold_eff;
  assign accept_nxt = (take || reload) ? now : accept_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
      started_r   <= 1'b0;
      stable_r    <= 1'b0;
      hold_r      <= '0;
      accept_r    <= '0;
      sent_r      <= '0;
      marks_len_r <= '0;
      high_r      <= 1'b0;
      low_r       <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        in_vld_r  <= 1'b1;
        in_item_r <= in_item;
      end else if (move) begin
        in_vld_r <= 1'b0;
      end

      if (move) begin
        out_vld_r               <= 1'b1;
        out_item_r.stable_level <= stable_nxt;
        out_item_r.high_seen    <= high_nxt;
        out_item_r.low_seen     <= low_nxt;
        out_item_r.fired_mask   <= fire;
        started_r               <= 1'b1;
        stable_r                <= stable_nxt;
        hold_r                  <= hold_nxt;
        accept_r                <= accept_nxt;
        sent_r                  <= sent_base | fire;
        marks_len_r             <= marks_len_nxt;
        high_r                  <= high_nxt;
        low_r                   <= low_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

endmodule
